FILE: hw/rtl/polygon_cell_canopy_marker_defines.svh
// ----------------------------------------------------------------------------
// Polygon cell canopy marker assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POLYGON_CELL_CANOPY_MARKER_DEFINES_SVH
`define POLYGON_CELL_CANOPY_MARKER_DEFINES_SVH

// condition true in the cycle after antecedent
`define PCM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcm assertion failed");

// condition true in the same cycle as antecedent
`define PCM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcm assertion failed");

`endif

FILE: hw/rtl/pcm_pkg.sv
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types and constants of the polygon cell canopy marker.
// ----------------------------------------------------------------------------
package pcm_pkg;

    localparam int MAX_VERTS_DEF  = 64;
    localparam int MAX_LEVELS_DEF = 256;
    localparam int COORD_BITS_DEF = 24;

    localparam int HGT_BITS  = 24;             // heights, Q16.8
    localparam int CW_BITS   = 16;             // cell width
    localparam int CIDX_BITS = 12;             // cell index
    localparam int CXW       = CIDX_BITS + 1 + CW_BITS; // doubled center
    localparam int CFG_BITS  = 24;

    localparam logic [1:0] REQ_VERT  = 2'd0;
    localparam logic [1:0] REQ_LEVEL = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [1:0] CFG_CWX   = 2'd0;
    localparam logic [1:0] CFG_CWY   = 2'd1;
    localparam logic [1:0] CFG_CBASE = 2'd2;
    localparam logic [1:0] CFG_CTOP  = 2'd3;

    typedef struct packed {
        logic load_vert;
        logic load_lvl;
        logic clear;
        logic q_start;
        logic run;
        logic finish;
    } pcm_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic scan_done;
    } pcm_stat_t;

endpackage

FILE: hw/rtl/pcm_ctrl.sv
// ----------------------------------------------------------------------------
// pcm_ctrl
// Sequencer: decodes requests, runs a query through walk/scan, then finish.
// ----------------------------------------------------------------------------
`include "polygon_cell_canopy_marker_defines.svh"

module pcm_ctrl
    import pcm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic [1:0] req_type,
    input  pcm_stat_t stat,
    output pcm_cmd_t  cmd,
    output logic      busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (req_type)
                        REQ_VERT:  cmd.load_vert = 1'b1;
                        REQ_LEVEL: cmd.load_lvl  = 1'b1;
                        REQ_CLEAR: cmd.clear     = 1'b1;
                        REQ_QUERY:
                        begin
                            cmd.q_start = 1'b1;
                            state_next  = ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                cmd.run = 1'b1;
                if (stat.walk_done && stat.scan_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    `PCM_ASSERT_NEXT(a_fin_idle, state_reg == ST_FIN, state_reg == ST_IDLE)
    `PCM_ASSERT_NEXT(a_query_run, cmd.q_start, state_reg == ST_RUN)
    `PCM_ASSERT_NEXT(a_load_idle, cmd.load_vert || cmd.load_lvl || cmd.clear,
        state_reg == ST_IDLE)
    `PCM_ASSERT_SAME(a_fin_done, cmd.finish, stat.walk_done && stat.scan_done)

endmodule

FILE: hw/rtl/pcm_dp.sv
// ----------------------------------------------------------------------------
// pcm_dp
// Datapath: vertex and level stores, crossing-test pipeline, level scan,
// result and span registers.
// ----------------------------------------------------------------------------
module pcm_dp
    import pcm_pkg::*;
#(
    parameter int MAX_VERTS  = MAX_VERTS_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int LC = $clog2(MAX_LEVELS + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pcm_cmd_t               cmd,
    output pcm_stat_t              stat,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [CFG_BITS-1:0]    cfg_wdata,
    input  logic [COORD_BITS-1:0]  vertex_x,
    input  logic [COORD_BITS-1:0]  vertex_y,
    input  logic [HGT_BITS-1:0]    level_center,
    input  logic [HGT_BITS-1:0]    level_face,
    input  logic [CIDX_BITS-1:0]   cell_i,
    input  logic [CIDX_BITS-1:0]   cell_j,
    input  logic [HGT_BITS-1:0]    terrain_height,
    input  logic                   footprint_free,
    output logic                   done,
    output logic                   inside_res,
    output logic                   marked,
    output logic [LC-1:0]          bottom_index,
    output logic [LC-1:0]          top_index,
    output logic [HGT_BITS:0]      canopy_bottom,
    output logic [HGT_BITS:0]      canopy_summit,
    output logic [HGT_BITS-1:0]    canopy_floor_face,
    output logic signed [HGT_BITS+1:0] canopy_span,
    output logic [LC-1:0]          span_lowest,
    output logic [LC-1:0]          span_highest
);

    localparam int VA = $clog2(MAX_VERTS);
    localparam int VC = $clog2(MAX_VERTS + 1);
    localparam int LA = $clog2(MAX_LEVELS);
    localparam int DW = ((CXW > COORD_BITS + 1) ? CXW : COORD_BITS + 1) + 1;
    localparam int EW = COORD_BITS + 2;
    localparam int PW = DW + EW;

    // configuration
    logic [CW_BITS-1:0]  cwx_reg, cwy_reg;
    logic [HGT_BITS-1:0] cbase_reg, ctop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cwx_reg   <= CW_BITS'(256);
            cwy_reg   <= CW_BITS'(256);
            cbase_reg <= '0;
            ctop_reg  <= HGT_BITS'(2560);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CWX:   cwx_reg   <= cfg_wdata[CW_BITS-1:0];
                CFG_CWY:   cwy_reg   <= cfg_wdata[CW_BITS-1:0];
                CFG_CBASE: cbase_reg <= cfg_wdata[HGT_BITS-1:0];
                CFG_CTOP:  ctop_reg  <= cfg_wdata[HGT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // stores
    logic [COORD_BITS-1:0] vx_mem [MAX_VERTS];
    logic [COORD_BITS-1:0] vy_mem [MAX_VERTS];
    logic [HGT_BITS-1:0]   lc_mem [MAX_LEVELS];
    logic [HGT_BITS-1:0]   lf_mem [MAX_LEVELS];
    logic [VC-1:0]         vcnt_reg;
    logic [LC-1:0]         lcnt_reg;

    // query operands
    logic [CXW-1:0]        xc_reg, yc_reg;
    logic [HGT_BITS:0]     cb_reg, ct_reg;
    logic                  ff_reg;

    // vertex walk
    logic [VC-1:0]         vi_reg;
    logic                  w_act_reg;
    logic                  vrv_reg;
    logic [COORD_BITS-1:0] vx_rd_reg, vy_rd_reg;
    logic [COORD_BITS-1:0] px_reg, py_reg, sx_reg, sy_reg;
    logic                  ld_mode_reg;
    logic                  e1_reg, e2_reg;
    logic                  dpos1_reg, dpos2_reg;
    logic signed [DW-1:0]  dxc_reg, dyc_reg;
    logic signed [EW-1:0]  dx1_reg, dd_reg;
    logic signed [PW-1:0]  p_reg, q_reg;
    logic                  par_reg;

    // level scan
    logic [LC-1:0]         li_reg;
    logic [LC-1:0]         lk_reg;
    logic                  l_act_reg;
    logic                  lrv_reg;
    logic [HGT_BITS-1:0]   lc_rd_reg, lf_rd_reg;
    logic                  bf_reg, tf_reg;
    logic [LC-1:0]         bidx_reg, tidx_reg;
    logic [HGT_BITS-1:0]   face_reg;

    // span tracking
    logic [LC-1:0]         lo_reg, hi_reg;
    logic                  any_reg;

    // edge stage 1 terms
    logic signed [DW-1:0]  dxc_next, dyc_next;
    logic signed [EW-1:0]  dx1_next, dd_next;
    logic                  cross_next;
    logic                  y0_le, y1_le;

    assign dxc_next = $signed(DW'(xc_reg)) - $signed(DW'({px_reg, 1'b0}));
    assign dyc_next = $signed(DW'(yc_reg)) - $signed(DW'({py_reg, 1'b0}));
    assign dx1_next = $signed(EW'({vx_rd_reg, 1'b0})) - $signed(EW'({px_reg, 1'b0}));
    assign dd_next  = $signed(EW'({vy_rd_reg, 1'b0})) - $signed(EW'({py_reg, 1'b0}));
    assign y0_le    = DW'({py_reg, 1'b0}) <= DW'(yc_reg);
    assign y1_le    = DW'({vy_rd_reg, 1'b0}) <= DW'(yc_reg);
    assign cross_next = (y0_le && !y1_le) || (!y0_le && y1_le);

    // memory writes and reads
    always_ff @(posedge clk)
    begin
        if (cmd.load_vert && (vcnt_reg < VC'(MAX_VERTS)))
        begin
            vx_mem[vcnt_reg[VA-1:0]] <= vertex_x;
            vy_mem[vcnt_reg[VA-1:0]] <= vertex_y;
        end
        if (cmd.run && w_act_reg)
        begin
            vx_rd_reg <= vx_mem[vi_reg[VA-1:0]];
            vy_rd_reg <= vy_mem[vi_reg[VA-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_lvl && (lcnt_reg < LC'(MAX_LEVELS)))
        begin
            lc_mem[lcnt_reg[LA-1:0]] <= level_center;
            lf_mem[lcnt_reg[LA-1:0]] <= level_face;
        end
        if (cmd.run && l_act_reg)
        begin
            lc_rd_reg <= lc_mem[li_reg[LA-1:0]];
            lf_rd_reg <= lf_mem[li_reg[LA-1:0]];
        end
    end

    // payload pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.q_start)
        begin
            xc_reg <= CXW'({cell_i, 1'b1} * cwx_reg);
            yc_reg <= CXW'({cell_j, 1'b1} * cwy_reg);
            cb_reg <= (HGT_BITS + 1)'(terrain_height) + (HGT_BITS + 1)'(cbase_reg);
            ct_reg <= (HGT_BITS + 1)'(terrain_height) + (HGT_BITS + 1)'(ctop_reg);
            ff_reg <= footprint_free;
        end
        if (vrv_reg)
        begin
            px_reg <= vx_rd_reg;
            py_reg <= vy_rd_reg;
            if (ld_mode_reg)
            begin
                sx_reg <= vx_rd_reg;
                sy_reg <= vy_rd_reg;
            end
        end
        dxc_reg   <= dxc_next;
        dyc_reg   <= dyc_next;
        dx1_reg   <= dx1_next;
        dd_reg    <= dd_next;
        dpos1_reg <= (dd_next > 0);
        p_reg     <= PW'(dxc_reg) * PW'(dd_reg);
        q_reg     <= PW'(dyc_reg) * PW'(dx1_reg);
        dpos2_reg <= dpos1_reg;
        lk_reg    <= li_reg;
    end

    // control state of the walk and scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg    <= '0;
            lcnt_reg    <= '0;
            vi_reg      <= '0;
            w_act_reg   <= 1'b0;
            vrv_reg     <= 1'b0;
            ld_mode_reg <= 1'b1;
            e1_reg      <= 1'b0;
            e2_reg      <= 1'b0;
            par_reg     <= 1'b0;
            li_reg      <= '0;
            l_act_reg   <= 1'b0;
            lrv_reg     <= 1'b0;
            bf_reg      <= 1'b0;
            tf_reg      <= 1'b0;
            bidx_reg    <= '0;
            tidx_reg    <= '0;
            face_reg    <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            any_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load_vert && (vcnt_reg < VC'(MAX_VERTS)))
            begin
                vcnt_reg <= vcnt_reg + 1'b1;
            end
            if (cmd.load_lvl && (lcnt_reg < LC'(MAX_LEVELS)))
            begin
                lcnt_reg <= lcnt_reg + 1'b1;
            end
            if (cmd.clear)
            begin
                vcnt_reg <= '0;
                lcnt_reg <= '0;
                lo_reg   <= '0;
                hi_reg   <= '0;
                any_reg  <= 1'b0;
            end

            // vertex walk: first read vertex (and one after a ring close) opens a ring
            vrv_reg <= cmd.run && w_act_reg;
            e1_reg  <= vrv_reg && !ld_mode_reg && cross_next;
            e2_reg  <= e1_reg;
            if (cmd.q_start)
            begin
                vi_reg      <= '0;
                w_act_reg   <= (vcnt_reg >= VC'(2));
                ld_mode_reg <= 1'b1;
                par_reg     <= 1'b0;
            end
            else
            begin
                if (cmd.run && w_act_reg)
                begin
                    vi_reg <= vi_reg + 1'b1;
                    if (vi_reg == vcnt_reg - 1'b1)
                    begin
                        w_act_reg <= 1'b0;
                    end
                end
                if (vrv_reg)
                begin
                    if (ld_mode_reg)
                    begin
                        ld_mode_reg <= 1'b0;
                    end
                    else
                    begin
                        ld_mode_reg <= (vx_rd_reg == sx_reg) && (vy_rd_reg == sy_reg);
                    end
                end
                if (e2_reg && (dpos2_reg ? (p_reg < q_reg) : (q_reg < p_reg)))
                begin
                    par_reg <= ~par_reg;
                end
            end

            // level scan from index 1, stops at end or when both searches hit
            lrv_reg <= cmd.run && l_act_reg;
            if (cmd.q_start)
            begin
                li_reg    <= LC'(1);
                l_act_reg <= (lcnt_reg >= LC'(2));
                bf_reg    <= 1'b0;
                tf_reg    <= 1'b0;
                bidx_reg  <= lcnt_reg;
                tidx_reg  <= lcnt_reg;
                face_reg  <= '0;
            end
            else
            begin
                if (cmd.run && l_act_reg)
                begin
                    li_reg <= li_reg + 1'b1;
                    if ((li_reg == lcnt_reg - 1'b1) || (bf_reg && tf_reg))
                    begin
                        l_act_reg <= 1'b0;
                    end
                end
                if (lrv_reg)
                begin
                    if (!bf_reg && (cb_reg <= (HGT_BITS + 1)'(lc_rd_reg)))
                    begin
                        bf_reg   <= 1'b1;
                        bidx_reg <= lk_reg;
                        face_reg <= lf_rd_reg;
                    end
                    if (!tf_reg && (ct_reg < (HGT_BITS + 1)'(lc_rd_reg)))
                    begin
                        tf_reg   <= 1'b1;
                        tidx_reg <= lk_reg;
                    end
                end
            end

            if (cmd.finish && par_reg && ff_reg)
            begin
                any_reg <= 1'b1;
                if (!any_reg || (bidx_reg < lo_reg))
                begin
                    lo_reg <= bidx_reg;
                end
                if (!any_reg || (tidx_reg > hi_reg))
                begin
                    hi_reg <= tidx_reg;
                end
            end
        end
    end

    assign stat.walk_done = !w_act_reg && !vrv_reg && !e1_reg && !e2_reg;
    assign stat.scan_done = !l_act_reg && !lrv_reg;

    // result register
    logic mk;
    assign mk = par_reg && ff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            inside_res        <= par_reg;
            marked            <= mk;
            bottom_index      <= mk ? bidx_reg : '0;
            top_index         <= mk ? tidx_reg : '0;
            canopy_bottom     <= mk ? cb_reg : '0;
            canopy_summit     <= mk ? ct_reg : '0;
            canopy_floor_face <= mk ? face_reg : '0;
            canopy_span       <= mk ? ($signed({1'b0, ct_reg}) - $signed({1'b0, cb_reg}))
                                    : '0;
        end
    end

    assign span_lowest  = lo_reg;
    assign span_highest = hi_reg;

endmodule

FILE: hw/rtl/polygon_cell_canopy_marker.sv
// ----------------------------------------------------------------------------
// polygon_cell_canopy_marker
// Even-odd point-in-polygon test of cell centers with canopy level lookup.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------
//  request  | start, busy         | req_type, vertex_*, level_*, cell_*,
//           |                     | terrain_height, footprint_free
//  result   | done (one cycle)    | inside_res ... span_highest
//  config   | cfg_we              | cfg_index, cfg_wdata
//
//  Loads and clear never raise busy; busy stays low.
//  A query holds busy high while the vertex walk and the level scan run, each
//  reading one store entry per cycle; the scan stops early once both levels
//  are found. done is high in the first cycle with busy low. rst_n is
//  asynchronous; stores are not cleared, counts and span are. The receiver
//  cannot stall results.
// ----------------------------------------------------------------------------
module polygon_cell_canopy_marker
    import pcm_pkg::*;
#(
    parameter int MAX_VERTS  = MAX_VERTS_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int LC = $clog2(MAX_LEVELS + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    output logic                   done,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [CFG_BITS-1:0]    cfg_wdata,
    input  logic [1:0]             req_type,
    input  logic [COORD_BITS-1:0]  vertex_x,
    input  logic [COORD_BITS-1:0]  vertex_y,
    input  logic [HGT_BITS-1:0]    level_center,
    input  logic [HGT_BITS-1:0]    level_face,
    input  logic [CIDX_BITS-1:0]   cell_i,
    input  logic [CIDX_BITS-1:0]   cell_j,
    input  logic [HGT_BITS-1:0]    terrain_height,
    input  logic                   footprint_free,
    output logic                   inside_res,
    output logic                   marked,
    output logic [LC-1:0]          bottom_index,
    output logic [LC-1:0]          top_index,
    output logic [HGT_BITS:0]      canopy_bottom,
    output logic [HGT_BITS:0]      canopy_summit,
    output logic [HGT_BITS-1:0]    canopy_floor_face,
    output logic signed [HGT_BITS+1:0] canopy_span,
    output logic [LC-1:0]          span_lowest,
    output logic [LC-1:0]          span_highest
);

    pcm_cmd_t  cmd;
    pcm_stat_t stat;

    pcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    pcm_dp #(
        .MAX_VERTS  (MAX_VERTS),
        .MAX_LEVELS (MAX_LEVELS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .vertex_x          (vertex_x),
        .vertex_y          (vertex_y),
        .level_center      (level_center),
        .level_face        (level_face),
        .cell_i            (cell_i),
        .cell_j            (cell_j),
        .terrain_height    (terrain_height),
        .footprint_free    (footprint_free),
        .done              (done),
        .inside_res        (inside_res),
        .marked            (marked),
        .bottom_index      (bottom_index),
        .top_index         (top_index),
        .canopy_bottom     (canopy_bottom),
        .canopy_summit     (canopy_summit),
        .canopy_floor_face (canopy_floor_face),
        .canopy_span       (canopy_span),
        .span_lowest       (span_lowest),
        .span_highest      (span_highest)
    );

endmodule

FILE: tb/polygon_cell_canopy_marker_tb.sv
// ----------------------------------------------------------------------------
// polygon_cell_canopy_marker_tb
// Self-checking bench: loads polygons and level tables, queries cells and
// checks every result against a built-in predictor of the crossing test and canopy
// level search, or for lit rows a typed-in result, under several cell size and crown height settings.
// ----------------------------------------------------------------------------
module polygon_cell_canopy_marker_tb;
    import pcm_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [23:0] vx;
        logic [23:0] vy;
        logic [23:0] lc;
        logic [23:0] lf;
        logic [11:0] ci;
        logic [11:0] cj;
        logic [23:0] terr;
        logic        free;
    } cell_req_t;

    typedef struct packed {
        logic        ins;
        logic        mk;
        logic [8:0]  bi;
        logic [8:0]  ti;
        logic [24:0] cb;
        logic [24:0] ct;
        logic [23:0] face;
        logic [25:0] span;
        logic [8:0]  lo;
        logic [8:0]  hi;
    } canopy_res_t;

    typedef struct {
        cell_req_t   r;
        bit          lit;
        canopy_res_t e;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        done;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_CWX;
    logic [23:0] cfg_wdata = '0;
    logic [1:0]  req_type = REQ_VERT;
    logic [23:0] vertex_x = '0;
    logic [23:0] vertex_y = '0;
    logic [23:0] level_center = '0;
    logic [23:0] level_face = '0;
    logic [11:0] cell_i = '0;
    logic [11:0] cell_j = '0;
    logic [23:0] terrain_height = '0;
    logic        footprint_free = 1'b0;
    logic        inside_res;
    logic        marked;
    logic [8:0]  bottom_index;
    logic [8:0]  top_index;
    logic [24:0] canopy_bottom;
    logic [24:0] canopy_summit;
    logic [23:0] canopy_floor_face;
    logic signed [25:0] canopy_span;
    logic [8:0]  span_lowest;
    logic [8:0]  span_highest;

    polygon_cell_canopy_marker dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [23:0] vx_mem [64];
    logic [23:0] vy_mem [64];
    logic [23:0] lc_mem [256];
    logic [23:0] lf_mem [256];
    int          n_verts, n_levels;
    logic [8:0]  low_bot, high_top;
    bit          seen_mark;
    logic [15:0] cw_x = 16'd256, cw_y = 16'd256;
    logic [23:0] crown_base = '0, crown_top = 24'd2560;

    canopy_res_t canopy_q[$];
    dir_row_t    dir_tab[$];
    int          n_err = 0;
    int          n_sent = 0;
    bit          no_gaps = 0;

    function automatic bit center_inside(longint xc, longint yc);
        int     v, s, n;
        longint x0, y0, x1, y1, d;
        bit     hit;
        if (n_verts < 2)
            return 0;
        v = 0; s = 0; n = 0;
        while (v < n_verts - 1)
        begin
            x0 = 2 * longint'(vx_mem[v]);     y0 = 2 * longint'(vy_mem[v]);
            x1 = 2 * longint'(vx_mem[v + 1]); y1 = 2 * longint'(vy_mem[v + 1]);
            if ((y0 <= yc && y1 > yc) || (y0 > yc && y1 <= yc))
            begin
                d = y1 - y0;
                if (d > 0)
                    hit = (xc - x0) * d < (yc - y0) * (x1 - x0);
                else
                    hit = (yc - y0) * (x1 - x0) < (xc - x0) * d;
                if (hit)
                    n++;
            end
            v++;
            // back at the ring start: close ring, next ring begins after it
            if (vx_mem[v] == vx_mem[s] && vy_mem[v] == vy_mem[s])
            begin
                v++;
                s = v;
            end
        end
        return n[0];
    endfunction

    function automatic bit predict_canopy(cell_req_t r, output canopy_res_t res);
        longint xc, yc;
        int     k;
        res = '0;
        case (r.kind)
            REQ_VERT:
            begin
                if (n_verts < 64)
                begin
                    vx_mem[n_verts] = r.vx; vy_mem[n_verts] = r.vy; n_verts++;
                end
                return 0;
            end
            REQ_LEVEL:
            begin
                if (n_levels < 256)
                begin
                    lc_mem[n_levels] = r.lc; lf_mem[n_levels] = r.lf; n_levels++;
                end
                return 0;
            end
            REQ_CLEAR:
            begin
                n_verts = 0; n_levels = 0; low_bot = 0; high_top = 0; seen_mark = 0;
                return 0;
            end
            default: ;
        endcase
        xc = (2 * longint'(r.ci) + 1) * longint'(cw_x);
        yc = (2 * longint'(r.cj) + 1) * longint'(cw_y);
        res.ins = center_inside(xc, yc);
        res.mk = res.ins && r.free;
        if (res.mk)
        begin
            res.cb = {1'b0, r.terr} + {1'b0, crown_base};
            res.ct = {1'b0, r.terr} + {1'b0, crown_top};
            res.bi = 9'(n_levels);
            for (k = 1; k < n_levels; k++)
                if ({1'b0, lc_mem[k]} >= res.cb)
                begin
                    res.bi = 9'(k); res.face = lf_mem[k]; break;
                end
            res.ti = 9'(n_levels);
            for (k = 1; k < n_levels; k++)
                if ({1'b0, lc_mem[k]} > res.ct)
                begin
                    res.ti = 9'(k); break;
                end
            res.span = {1'b0, res.ct} - {1'b0, res.cb};
            if (!seen_mark)
            begin
                low_bot = res.bi; high_top = res.ti; seen_mark = 1;
            end
            else
            begin
                if (res.bi < low_bot) low_bot = res.bi;
                if (res.ti > high_top) high_top = res.ti;
            end
        end
        res.lo = low_bot;
        res.hi = high_top;
        return 1;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        canopy_res_t act, exp_r;
        if (rst_n && done)
        begin
            act = '{inside_res, marked, bottom_index, top_index, canopy_bottom, canopy_summit,
                    canopy_floor_face, canopy_span, span_lowest, span_highest};
            if (canopy_q.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result %p", act);
            end
            else
            begin
                exp_r = canopy_q.pop_front();
                if (act !== exp_r)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, act);
                end
            end
        end
    end

    // drive one item and wait for it to be taken; start stays high when no gap follows
    task automatic send_item(cell_req_t r, bit lit = 0, canopy_res_t lit_res = '0);
        canopy_res_t res;
        canopy_res_t exp_e;
        int          gap;
        req_type <= r.kind;
        vertex_x <= r.vx; vertex_y <= r.vy;
        level_center <= r.lc; level_face <= r.lf;
        cell_i <= r.ci; cell_j <= r.cj;
        terrain_height <= r.terr; footprint_free <= r.free;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        if (predict_canopy(r, res))
        begin
            exp_e = lit ? lit_res : res;
            canopy_q = {canopy_q, exp_e};
        end
        n_sent++;
        gap = no_gaps ? 0 : int'($urandom_range(0, 7));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        int n;
        start <= 1'b0;
        n = 0;
        while (canopy_q.size() != 0 && n < 2000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CWX:   cw_x = val[15:0];
            CFG_CWY:   cw_y = val[15:0];
            CFG_CBASE: crown_base = val;
            default:   crown_top = val;
        endcase
        @(posedge clk);
    endtask

    function automatic cell_req_t rnd_req();
        cell_req_t r;
        r.kind = 2'($urandom_range(0, 3));
        r.vx = 24'($urandom); r.vy = 24'($urandom);
        r.lc = 24'($urandom); r.lf = 24'($urandom);
        r.ci = 12'($urandom); r.cj = 12'($urandom);
        r.terr = 24'($urandom); r.free = 1'($urandom);
        return r;
    endfunction

    function automatic cell_req_t mk(logic [1:0] kind, logic [23:0] a = 0, logic [23:0] b = 0,
                                     logic [23:0] t = 0, logic f = 0);
        cell_req_t r;
        r = rnd_req();
        r.kind = kind;
        if (kind == REQ_VERT)  begin r.vx = a; r.vy = b; end
        if (kind == REQ_LEVEL) begin r.lc = a; r.lf = b; end
        if (kind == REQ_QUERY)
        begin
            r.ci = a[11:0]; r.cj = b[11:0]; r.terr = t; r.free = f;
        end
        return r;
    endfunction

    function automatic void add_row(cell_req_t r, bit lit = 0, canopy_res_t e = '0);
        dir_row_t row;
        row.r = r; row.lit = lit; row.e = e;
        dir_tab = {dir_tab, row};
    endfunction

    initial
    begin
        int          n, k, ph;
        logic [23:0] bx, by, c, fx, fy;
        n_verts = 0; n_levels = 0; low_bot = 0; high_top = 0; seen_mark = 0;

        // directed table; lit rows carry a typed-in result (all zero here)
        add_row(mk(REQ_QUERY, 0, 0, 0, 1), 1);
        add_row(mk(REQ_VERT, 0, 0));
        add_row(mk(REQ_QUERY, 0, 0, 0, 1), 1);
        add_row(mk(REQ_VERT, 2560, 0));
        add_row(mk(REQ_VERT, 2560, 2560));
        add_row(mk(REQ_VERT, 0, 2560));
        add_row(mk(REQ_VERT, 0, 0));
        add_row(mk(REQ_LEVEL, 0, 0));
        add_row(mk(REQ_LEVEL, 256, 128));
        add_row(mk(REQ_LEVEL, 512, 384));
        add_row(mk(REQ_LEVEL, 1024, 768));
        add_row(mk(REQ_LEVEL, 4096, 3000));
        add_row(mk(REQ_QUERY, 200, 200, 0, 1), 1);
        add_row(mk(REQ_QUERY, 2, 3, 0, 1));
        add_row(mk(REQ_QUERY, 2, 3, 0, 0));
        add_row(mk(REQ_QUERY, 9, 9, 24'hFFFFFF, 1));
        add_row(mk(REQ_QUERY, 4095, 4095, 24'hFFFFFF, 1));
        add_row(mk(REQ_VERT, 24'hFFFFFF, 24'hFFFFFF));
        add_row(mk(REQ_LEVEL, 24'hFFFFFF, 24'hFFFFFF));
        add_row(mk(REQ_QUERY, 0, 9, 0, 1));
        add_row(mk(REQ_CLEAR));
        add_row(mk(REQ_QUERY, 2, 3, 0, 1), 1);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i].r, dir_tab[i].lit, dir_tab[i].e);

        for (ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0: begin write_reg(CFG_CWX, 1); write_reg(CFG_CWY, 1);
                         write_reg(CFG_CBASE, 0); write_reg(CFG_CTOP, 0); end
                1: begin write_reg(CFG_CWX, 16'hFFFF); write_reg(CFG_CWY, 16'hFFFF);
                         write_reg(CFG_CBASE, 24'hFFFFFF); write_reg(CFG_CTOP, 24'hFFFFFF); end
                2: begin write_reg(CFG_CWX, 256); write_reg(CFG_CWY, 512);
                         write_reg(CFG_CBASE, 1000); write_reg(CFG_CTOP, 9000); end
                default: begin write_reg(CFG_CWX, 24'($urandom_range(1, 65535)));
                         write_reg(CFG_CWY, 24'($urandom_range(1, 65535)));
                         write_reg(CFG_CBASE, 24'($urandom_range(0, 12000)));
                         write_reg(CFG_CTOP, 24'($urandom_range(0, 20000))); end
            endcase
            while (n_sent < 22 + (ph + 1) * 222)
            begin
                no_gaps = ($urandom_range(0, 3) == 0);
                send_item(mk(REQ_CLEAR));
                bx = {4'd0, cw_x, 4'd0};
                by = {4'd0, cw_y, 4'd0};
                // one or two closed rings, occasionally overfilled
                for (int ring = 0; ring < (($urandom_range(0, 3) == 0) ? 2 : 1); ring++)
                begin
                    n = $urandom_range(3, 10);
                    fx = 24'($urandom_range(0, bx)); fy = 24'($urandom_range(0, by));
                    send_item(mk(REQ_VERT, fx, fy));
                    for (k = 1; k < n; k++)
                        send_item(mk(REQ_VERT, 24'($urandom_range(0, bx)),
                                     24'($urandom_range(0, by))));
                    send_item(mk(REQ_VERT, fx, fy));
                end
                if ($urandom_range(0, 9) == 0)
                    repeat (66) send_item(mk(REQ_VERT, 24'($urandom), 24'($urandom)));
                n = ($urandom_range(0, 14) == 0) ? 260 : $urandom_range(2, 24);
                c = 24'($urandom_range(0, 500));
                for (k = 0; k < n; k++)
                begin
                    send_item(mk(REQ_LEVEL, c, c - 24'($urandom_range(0, 200))));
                    c += (n > 30) ? 24'($urandom_range(0, 120)) : 24'($urandom_range(0, 3000));
                end
                n = $urandom_range(4, 12);
                for (k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 6) == 0)
                        send_item(rnd_req());
                    else
                        send_item(mk(REQ_QUERY, 24'($urandom_range(0, 17)),
                                     24'($urandom_range(0, 17)),
                                     24'($urandom_range(0, 20000)),
                                     $urandom_range(0, 4) != 0));
                end
            end
        end

        drain();
        if (n_err == 0 && canopy_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #16000000;
        $display("Verification failed");
        $finish;
    end

endmodule
